>>> rtl/lap4_pkg.sv
package lap4_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RESULT_W  = 19;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_SLOTS = 3;
    localparam int ENTRY_W   = NUM_SLOTS * SAMPLE_W;
    localparam int SUM_W     = SAMPLE_W + 2;   // up to four samples
    localparam int CNT_W     = 3;              // neighbour count 0..4

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(768);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [1:0]          slot_t;    // row slot 0..2

    localparam slot_t SLOT_0 = 2'd0;
    localparam slot_t SLOT_1 = 2'd1;
    localparam slot_t SLOT_2 = 2'd2;

    // one memory word holds the same column of all three line slots
    function automatic sample_t slot_get(entry_t e, slot_t s);
        sample_t v;
        case (s)
            SLOT_0:  v = e[SAMPLE_W-1:0];
            SLOT_1:  v = e[2*SAMPLE_W-1:SAMPLE_W];
            default: v = e[3*SAMPLE_W-1:2*SAMPLE_W];
        endcase
        return v;
    endfunction

    function automatic entry_t slot_put(entry_t e, slot_t s, sample_t v);
        entry_t r;
        r = e;
        case (s)
            SLOT_0:  r[SAMPLE_W-1:0]            = v;
            SLOT_1:  r[2*SAMPLE_W-1:SAMPLE_W]   = v;
            default: r[3*SAMPLE_W-1:2*SAMPLE_W] = v;
        endcase
        return r;
    endfunction

    function automatic slot_t slot_inc(slot_t s);
        return (s == SLOT_2) ? SLOT_0 : slot_t'(s + 2'd1);
    endfunction

    function automatic slot_t slot_dec(slot_t s);
        return (s == SLOT_0) ? SLOT_2 : slot_t'(s - 2'd1);
    endfunction

    // center * n - sum, two's complement
    function automatic logic signed [RESULT_W-1:0] lap_value(sample_t c,
                                                             logic [SUM_W-1:0] sum,
                                                             logic [CNT_W-1:0] n);
        logic [SAMPLE_W+CNT_W-1:0] prod;
        logic [SAMPLE_W+CNT_W:0]   diff;
        prod = (SAMPLE_W + CNT_W)'(c) * (SAMPLE_W + CNT_W)'(n);
        diff = {1'b0, prod} - (SAMPLE_W + CNT_W + 1)'(sum);
        return diff[RESULT_W-1:0];
    endfunction

endpackage

>>> rtl/lap4_ram.sv
module lap4_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/laplacian_4_neighbour_stream_core.sv
// 4-neighbour Laplacian over a raster-order luma stream. Each accepted sample
// (x,y) with y > 0 yields the result for (x,y-1); in the last row it also
// yields the result for (x-1,y), and the frame's final pixel adds its own
// result, so one request gives up to three results, the last one flagged by
// m_last_of_run. Throughput is one sample per clock in every row but the last
// while m_ready stays high; there the single result port sets the pace, and no
// sample is taken until every result of the one before it is loaded.
// The three line stores live in one simple dual-port RAM, one word per column
// holding all three row slots; each sample reads the word one column ahead and
// writes its own column back as it leaves stage 2 (read-modify-write, with
// forwarding when the two touch the same word). Every configuration write
// reloads the column window from the RAM: s_ready stays low through reload
// states R0 to R3 after the last write. Sizes of 0 count as 1, sizes above the
// maximum are clamped, and a position beyond a newly shrunk size sits on the
// last column or row.
module laplacian_4_neighbour_stream_core
    import lap4_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // sample requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_W-1:0]        s_sample,
    // result requests
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RESULT_W-1:0] m_result,
    output logic [COORD_W-1:0]         m_column,
    output logic [COORD_W-1:0]         m_row,
    output logic                       m_last_of_run,
    output logic                       m_end_of_frame,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef logic [XW-1:0] xpos_t;
    typedef logic [YW-1:0] ypos_t;

    // result kinds, one bit each, emitted lowest first
    localparam logic [2:0] RES_UP    = 3'b001;  // (x, y-1)
    localparam logic [2:0] RES_LEFT  = 3'b010;  // (x-1, y), last row
    localparam logic [2:0] RES_FINAL = 3'b100;  // (x, y), frame end

    typedef enum logic [2:0] {
        RF_RUN,
        RF_R0,
        RF_R1,
        RF_R2,
        RF_R3
    } rf_state_t;

    typedef struct packed {
        sample_t    sample;
        xpos_t      x;
        ypos_t      y;
        slot_t      sel;
        logic [2:0] rem;      // results still to send
        logic       xpos;     // x > 0
        logic       xge2;     // x > 1
        logic       xlast;    // x is the last column
        logic       ygt0;
        logic       ygt1;
        logic       self_fwd; // look-ahead word is the one this sample writes
        logic       fwd;      // look-ahead word taken from the previous write
    } st2_t;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_width_reg, cfg_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= FRAME_WIDTH_RST;
            cfg_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: cfg_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [31:0] fw_ext, fh_ext;
    xpos_t       wm1;   // last column
    ypos_t       hm1;   // last row

    assign fw_ext = 32'(cfg_width_reg);
    assign fh_ext = 32'(cfg_height_reg);

    always_comb begin
        if (fw_ext == 32'd0) begin
            wm1 = '0;
        end else if (fw_ext > 32'(MAX_WIDTH)) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(fw_ext - 32'd1);
        end
        if (fh_ext == 32'd0) begin
            hm1 = '0;
        end else if (fh_ext > 32'(MAX_HEIGHT)) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(fh_ext - 32'd1);
        end
    end

    // ------------------------------------------------------------------
    // position counters and stage 1 (request accept, look-ahead read)
    // ------------------------------------------------------------------
    xpos_t     col_cnt_reg;
    ypos_t     row_cnt_reg;
    slot_t     row_sel_reg;
    rf_state_t rf_state_reg, rf_state_next;

    xpos_t      x, rd_addr_run;
    ypos_t      y;
    logic       row_end, last_row, accept;
    logic [2:0] res_mask;

    assign x        = (col_cnt_reg > wm1) ? wm1 : col_cnt_reg;
    assign y        = (row_cnt_reg > hm1) ? hm1 : row_cnt_reg;
    assign row_end  = (x == wm1);
    assign last_row = (y == hm1);

    // fetch next column's word; at row end the first column of the next row
    assign rd_addr_run = row_end ? '0 : xpos_t'(x + XW'(1));

    assign res_mask = ((y != '0) ? RES_UP : 3'b000)
                    | ((last_row && (x != '0)) ? RES_LEFT : 3'b000)
                    | ((last_row && row_end) ? RES_FINAL : 3'b000);

    st2_t st2_reg;
    logic st2_valid_reg, st2_done;

    assign s_ready = (rf_state_reg == RF_RUN) && (!st2_valid_reg || st2_done);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            row_sel_reg <= SLOT_0;
        end else if (accept) begin
            if (row_end) begin
                col_cnt_reg <= '0;
                if (last_row) begin
                    row_cnt_reg <= '0;
                    row_sel_reg <= SLOT_0;
                end else begin
                    row_cnt_reg <= ypos_t'(y + YW'(1));
                    row_sel_reg <= slot_inc(row_sel_reg);
                end
            end else begin
                col_cnt_reg <= xpos_t'(x + XW'(1));
                row_cnt_reg <= y;
            end
        end
    end

    // ------------------------------------------------------------------
    // line store RAM and column window
    // ------------------------------------------------------------------
    entry_t ent0_reg;      // word of column x as stored before this row's write
    entry_t entm1_reg;     // word of column x-1 after this row's write
    sample_t cm2_reg;      // current row, column x-2
    entry_t fwd_data_reg;

    entry_t ram_rd_data, wdata, rd_eff;
    xpos_t  ram_rd_addr;
    logic   ram_rd_en, fwd_hit;

    assign wdata  = slot_put(ent0_reg, st2_reg.sel, st2_reg.sample);
    assign rd_eff = st2_reg.self_fwd ? wdata :
                    st2_reg.fwd      ? fwd_data_reg : ram_rd_data;

    // write of the finishing sample lands on the word being fetched now
    assign fwd_hit = st2_done && (rd_addr_run == st2_reg.x);

    always_comb begin
        case (rf_state_reg)
            RF_R0:   ram_rd_addr = x;
            RF_R1:   ram_rd_addr = (x != '0) ? xpos_t'(x - XW'(1)) : '0;
            RF_R2:   ram_rd_addr = (x > XW'(1)) ? xpos_t'(x - XW'(2)) : '0;
            default: ram_rd_addr = rd_addr_run;
        endcase
    end

    assign ram_rd_en = accept || (rf_state_reg == RF_R0) || (rf_state_reg == RF_R1)
                     || (rf_state_reg == RF_R2);

    lap4_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (st2_done),
        .wr_addr (st2_reg.x),
        .wr_data (wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // window reload after a config write: fetch x, x-1, x-2
    always_comb begin
        rf_state_next = rf_state_reg;
        if (cfg_wr_en) begin
            rf_state_next = RF_R0;
        end else begin
            case (rf_state_reg)
                RF_R0:   rf_state_next = RF_R1;
                RF_R1:   rf_state_next = RF_R2;
                RF_R2:   rf_state_next = RF_R3;
                RF_R3:   rf_state_next = RF_RUN;
                default: rf_state_next = RF_RUN;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_state_reg <= RF_RUN;
        end else begin
            rf_state_reg <= rf_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (rf_state_reg)
            RF_R1: ent0_reg  <= ram_rd_data;
            RF_R2: entm1_reg <= ram_rd_data;
            RF_R3: cm2_reg   <= slot_get(ram_rd_data, row_sel_reg);
            default: begin
                if (st2_done) begin
                    cm2_reg   <= slot_get(entm1_reg, st2_reg.sel);
                    entm1_reg <= wdata;
                    ent0_reg  <= rd_eff;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= wdata;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: kernel and result sequencing
    // ------------------------------------------------------------------
    slot_t   sp, spp;
    sample_t c_up, c_left;
    logic [SUM_W-1:0] sum_up, sum_left, sum_fin;
    logic [CNT_W-1:0] n_up, n_left, n_fin;
    logic signed [RESULT_W-1:0] v_up, v_left, v_fin;
    logic [2:0] pick, rem_after;
    logic       out_load;

    assign sp  = slot_dec(st2_reg.sel);   // row above
    assign spp = slot_inc(st2_reg.sel);   // two rows above

    always_comb begin
        // (x, y-1): down neighbour is the new sample
        c_up   = slot_get(ent0_reg, sp);
        sum_up = SUM_W'(st2_reg.sample)
               + (st2_reg.xpos   ? SUM_W'(slot_get(entm1_reg, sp)) : '0)
               + (!st2_reg.xlast ? SUM_W'(slot_get(rd_eff, sp))    : '0)
               + (st2_reg.ygt1   ? SUM_W'(slot_get(ent0_reg, spp)) : '0);
        n_up   = CNT_W'(1) + CNT_W'(st2_reg.xpos) + CNT_W'(!st2_reg.xlast)
               + CNT_W'(st2_reg.ygt1);

        // (x-1, y): right neighbour is the new sample
        c_left   = slot_get(entm1_reg, st2_reg.sel);
        sum_left = SUM_W'(st2_reg.sample)
                 + (st2_reg.xge2 ? SUM_W'(cm2_reg) : '0)
                 + (st2_reg.ygt0 ? SUM_W'(slot_get(entm1_reg, sp)) : '0);
        n_left   = CNT_W'(1) + CNT_W'(st2_reg.xge2) + CNT_W'(st2_reg.ygt0);

        // (x, y): bottom-right pixel
        sum_fin = (st2_reg.xpos ? SUM_W'(slot_get(entm1_reg, st2_reg.sel)) : '0)
                + (st2_reg.ygt0 ? SUM_W'(slot_get(ent0_reg, sp)) : '0);
        n_fin   = CNT_W'(st2_reg.xpos) + CNT_W'(st2_reg.ygt0);
    end

    assign v_up   = lap_value(c_up, sum_up, n_up);
    assign v_left = lap_value(c_left, sum_left, n_left);
    assign v_fin  = lap_value(st2_reg.sample, sum_fin, n_fin);

    logic m_valid_reg;

    assign pick      = st2_reg.rem & (~st2_reg.rem + 3'b001);
    assign rem_after = st2_reg.rem & ~pick;
    assign out_load  = st2_valid_reg && (st2_reg.rem != 3'b000)
                     && (!m_valid_reg || m_ready);
    assign st2_done  = st2_valid_reg
                     && ((st2_reg.rem == 3'b000) || (out_load && (rem_after == 3'b000)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (accept) begin
            st2_valid_reg <= 1'b1;
        end else if (st2_done) begin
            st2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st2_reg.sample   <= s_sample;
            st2_reg.x        <= x;
            st2_reg.y        <= y;
            st2_reg.sel      <= row_sel_reg;
            st2_reg.rem      <= res_mask;
            st2_reg.xpos     <= (x != '0);
            st2_reg.xge2     <= (x > XW'(1));
            st2_reg.xlast    <= row_end;
            st2_reg.ygt0     <= (y != '0);
            st2_reg.ygt1     <= (y > YW'(1));
            st2_reg.self_fwd <= (rd_addr_run == x);
            st2_reg.fwd      <= fwd_hit;
        end else if (out_load) begin
            st2_reg.rem <= rem_after;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [RESULT_W-1:0] m_result_reg;
    logic [COORD_W-1:0]         m_column_reg, m_row_reg;
    logic                       m_last_reg, m_eof_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_last_reg <= (rem_after == 3'b000);
            if (pick == RES_UP) begin
                m_result_reg <= v_up;
                m_column_reg <= COORD_W'(st2_reg.x);
                m_row_reg    <= COORD_W'(ypos_t'(st2_reg.y - YW'(1)));
                m_eof_reg    <= 1'b0;
            end else if (pick == RES_LEFT) begin
                m_result_reg <= v_left;
                m_column_reg <= COORD_W'(xpos_t'(st2_reg.x - XW'(1)));
                m_row_reg    <= COORD_W'(st2_reg.y);
                m_eof_reg    <= 1'b0;
            end else begin
                m_result_reg <= v_fin;
                m_column_reg <= COORD_W'(st2_reg.x);
                m_row_reg    <= COORD_W'(st2_reg.y);
                m_eof_reg    <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result       = m_result_reg;
    assign m_column       = m_column_reg;
    assign m_row          = m_row_reg;
    assign m_last_of_run  = m_last_reg;
    assign m_end_of_frame = m_eof_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_last_of_run)
        else $error("end_of_frame result not last of its run");

    a_accept_fills_st2: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st2_valid_reg)
        else $error("accepted request did not reach stage 2");

    a_row_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_sel_reg != 2'd3)
        else $error("row slot out of range");

    a_no_reload_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (rf_state_reg == RF_R1) |-> !st2_done)
        else $error("window reload overlaps a stage 2 write-back");

endmodule

>>> tb/tb_laplacian_4_neighbour_stream_core.sv
module tb_laplacian_4_neighbour_stream_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lap4_pkg::*;

    // run control
    localparam int unsigned HOLD_CYCLES    = 400;   // long receiver back-pressure stretch
    localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no request moving
    localparam int unsigned SETTLE_CYCLES  = 8;     // block may still write back a sample
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS    = 50;    // keep the log short on a bad build
    localparam int unsigned RANDOM_ITEMS   = 140;   // per idle mode, three modes
    localparam int unsigned FRAME_END      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [RESULT_W-1:0] lap;
        logic [COORD_W-1:0]         column;
        logic [COORD_W-1:0]         row;
        logic                       last;
        logic                       eof;
    } lap_result_t;

    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [SAMPLE_W-1:0]        s_sample       = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [RESULT_W-1:0] m_result;
    logic [COORD_W-1:0]         m_column;
    logic [COORD_W-1:0]         m_row;
    logic                       m_last_of_run;
    logic                       m_end_of_frame;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]           cfg_wdata      = '0;

    laplacian_4_neighbour_stream_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    sample_t      sample_q [$];       // samples waiting for the driver
    lap_result_t  lap_expect_q [$];   // predicted results, oldest first
    int unsigned  items_fed    = 0;   // samples handed to the driver
    int unsigned  items_taken  = 0;   // sample requests accepted by the block
    int unsigned  errors       = 0;
    int unsigned  send_idle_pct = 31;
    int unsigned  take_idle_pct = 70;
    int unsigned  hold_requests = 0;  // bumped by the sequencer
    int unsigned  hold_served   = 0;  // owned by the receiver
    int unsigned  hold_left     = 0;
    int unsigned  quiet_cycles  = 0;
    lap_result_t  got_r, want_r;

    // Generator-side raster position, so the sequencer knows where frames end.
    logic [CFG_W-1:0] feed_w_raw = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] feed_h_raw = FRAME_HEIGHT_RST;
    int unsigned      feed_col   = 0;
    int unsigned      feed_row   = 0;

    // Predictor state: three line slots, raster counters and the size registers.
    sample_t          luma_mem [3][DEF_MAX_WIDTH];
    int unsigned      pos_col     = 0;
    int unsigned      pos_row     = 0;
    int unsigned      cur_slot    = 0;
    logic [CFG_W-1:0] frame_w_reg = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] frame_h_reg = FRAME_HEIGHT_RST;

    initial begin
        foreach (luma_mem[i, j]) luma_mem[i][j] = '0;
    end

    // Size 0 counts as 1, anything above the maximum is clamped.
    function automatic int unsigned eff_size(logic [CFG_W-1:0] raw, int unsigned maxv);
        int unsigned v;
        v = raw;
        if (v == 0) v = 1;
        if (v > maxv) v = maxv;
        return v;
    endfunction

    // Advance raster counters by one pixel. Counters beyond a shrunk size sit
    // on the last column/row. Returns 1 when this pixel closes the frame.
    function automatic bit step_raster(input int unsigned w, input int unsigned h,
                                       inout int unsigned col, inout int unsigned row);
        int unsigned x, y;
        bit          ended;
        x = (col > w - 1) ? w - 1 : col;
        y = (row > h - 1) ? h - 1 : row;
        ended = 1'b0;
        if (x == w - 1) begin
            col = 0;
            if (y == h - 1) begin
                row   = 0;
                ended = 1'b1;
            end else begin
                row = y + 1;
            end
        end else begin
            col = x + 1;
            row = y;
        end
        return ended;
    endfunction

    function automatic lap_result_t make_result(int c, int s, int n, int unsigned col,
                                                int unsigned row, bit eof);
        lap_result_t r;
        r.lap    = RESULT_W'(c * n - s);
        r.column = COORD_W'(col);
        r.row    = COORD_W'(row);
        r.last   = 1'b0;
        r.eof    = eof;
        return r;
    endfunction

    // Write the sample into the current line slot, then emit:
    //   - the pixel above (x,y-1), whose lower neighbour just arrived
    //   - in the last row, the pixel to the left (x-1,y)
    //   - at the frame's last pixel, that pixel itself
    function automatic void predict_laplacian(sample_t smp);
        int unsigned w, h, x, y, cs, ps, pps;
        int          c, s, n;
        bit          ended;
        lap_result_t res [$];
        w   = eff_size(frame_w_reg, DEF_MAX_WIDTH);
        h   = eff_size(frame_h_reg, DEF_MAX_HEIGHT);
        x   = (pos_col > w - 1) ? w - 1 : pos_col;
        y   = (pos_row > h - 1) ? h - 1 : pos_row;
        cs  = cur_slot;
        ps  = (cs + 2) % 3;
        pps = (cs + 1) % 3;
        luma_mem[cs][x] = smp;

        if (y > 0) begin
            c = luma_mem[ps][x];
            s = luma_mem[cs][x];
            n = 1;
            if (x > 0)     begin s += luma_mem[ps][x-1]; n++; end
            if (x < w - 1) begin s += luma_mem[ps][x+1]; n++; end
            if (y > 1)     begin s += luma_mem[pps][x];  n++; end
            res.push_back(make_result(c, s, n, x, y - 1, 1'b0));
        end
        if (y == h - 1) begin
            if (x > 0) begin
                c = luma_mem[cs][x-1];
                s = luma_mem[cs][x];
                n = 1;
                if (x > 1) begin s += luma_mem[cs][x-2]; n++; end
                if (y > 0) begin s += luma_mem[ps][x-1]; n++; end
                res.push_back(make_result(c, s, n, x - 1, y, 1'b0));
            end
            if (x == w - 1) begin
                c = luma_mem[cs][x];
                s = 0;
                n = 0;
                if (x > 0) begin s += luma_mem[cs][x-1]; n++; end
                if (y > 0) begin s += luma_mem[ps][x];   n++; end
                res.push_back(make_result(c, s, n, x, y, 1'b1));
            end
        end
        if (res.size() != 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) lap_expect_q.push_back(res[i]);

        ended = step_raster(w, h, pos_col, pos_row);
        if (x == w - 1) cur_slot = ended ? 0 : (cs + 1) % 3;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: valid holds with stable payload until the request goes
    // through; new requests are withheld at random per the idle percentage.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= sample_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Input monitor: register writes and accepted sample requests feed the
    // predictor. Writes only happen while the block is idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pos_col     = 0;
            pos_row     = 0;
            cur_slot    = 0;
            frame_w_reg = FRAME_WIDTH_RST;
            frame_h_reg = FRAME_HEIGHT_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w_reg = cfg_wdata;
                    REG_FRAME_HEIGHT: frame_h_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_laplacian(s_sample);
                items_taken++;
            end
        end
    end

    // Result receiver: random ready, plus a long hold-off when the sequencer
    // asks for one, so the block backs up and drops s_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_r.lap    = m_result;
            got_r.column = m_column;
            got_r.row    = m_row;
            got_r.last   = m_last_of_run;
            got_r.eof    = m_end_of_frame;
            if (lap_expect_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual lap=%0d col=%0d",
                             $time, got_r.lap, got_r.column,
                             " row=%0d last=%0b eof=%0b", got_r.row, got_r.last, got_r.eof);
            end else begin
                want_r = lap_expect_q.pop_front();
                if (got_r !== want_r) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch, expected lap=%0d col=%0d row=%0d last=%0b",
                                 $time, want_r.lap, want_r.column, want_r.row, want_r.last,
                                 " eof=%0b, actual lap=%0d col=%0d row=%0d last=%0b eof=%0b",
                                 want_r.eof, got_r.lap, got_r.column, got_r.row,
                                 got_r.last, got_r.eof);
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        feed_w_raw = w_raw;
        feed_h_raw = h_raw;
    endtask

    // Block is idle: every sample taken, every result seen, write-back done.
    // Also the sender's "pause until drained" point.
    task automatic wait_quiet();
        while (items_taken != items_fed || lap_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Extremes and small offsets from both rails are favored.
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(15));
            3:       return ~sample_t'($urandom_range(15));
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic bit feed_value(sample_t v);
        sample_q.push_back(v);
        items_fed++;
        return step_raster(eff_size(feed_w_raw, DEF_MAX_WIDTH),
                           eff_size(feed_h_raw, DEF_MAX_HEIGHT), feed_col, feed_row);
    endfunction

    // Random samples until the frame closes or the limit is reached.
    task automatic feed(int unsigned limit);
        int unsigned k;
        bit          ended;
        k     = 0;
        ended = 1'b0;
        while (!ended && k < limit) begin
            ended = feed_value(pick_sample());
            k++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned mode, budget, w_eff, h_eff;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait_quiet();

        // Directed: 3x3 frames putting the largest positive and negative
        // Laplacian on the center pixel.
        set_size(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) void'(feed_value((i == 4) ? 16'hFFFF : 16'h0000));
        for (int i = 0; i < 9; i++) void'(feed_value((i == 4) ? 16'h0000 : 16'hFFFF));
        // zero sizes count as one: single pixel, no neighbours
        wait_quiet();
        set_size(13'd0, 13'd0);
        void'(feed_value(16'hA5A5));
        // single row: lagging results plus the extra one at the end
        wait_quiet();
        set_size(13'd4, 13'd1);
        feed(FRAME_END);
        // single column: no left neighbour, no lagging results
        wait_quiet();
        set_size(13'd1, 13'd3);
        feed(FRAME_END);

        // Random frames over three idle modes.
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin send_idle_pct = 31; take_idle_pct = 70; end
                1:       begin send_idle_pct = 70; take_idle_pct = 31; end
                default: begin send_idle_pct = 0;  take_idle_pct = 0;  end
            endcase

            if (mode == 0) begin
                // receiver stalls for a long while as a frame streams in; the
                // last row doubles the result rate so the block fills fast
                wait_quiet();
                set_size(13'd10, 13'd5);
                hold_requests++;
                feed(FRAME_END);
            end

            budget = items_fed + RANDOM_ITEMS;
            while (items_fed < budget) begin
                // half the time frames run back to back with no drain
                if ($urandom_range(1) == 0) begin
                    wait_quiet();
                    set_size(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 6)));
                end
                w_eff = eff_size(feed_w_raw, DEF_MAX_WIDTH);
                h_eff = eff_size(feed_h_raw, DEF_MAX_HEIGHT);
                // size change mid-frame: width may only shrink so every line
                // store entry read later has been written in this frame
                if (w_eff * h_eff > 1 && $urandom_range(3) == 0) begin
                    feed($urandom_range(1, w_eff * h_eff - 1));
                    wait_quiet();
                    set_size(CFG_W'($urandom_range(0, w_eff)), CFG_W'($urandom_range(0, 7)));
                end
                feed(FRAME_END);
            end
        end

        // Largest sizes, no idling: full 4096-wide row (oversized width
        // clamps), then a 4096-row single-column frame.
        wait_quiet();
        set_size(13'h1FFF, 13'd1);
        feed(FRAME_END);
        wait_quiet();
        set_size(13'd0, 13'h1000);
        feed(FRAME_END);
        // oversized height, then cut to two rows while on row 2: that row
        // becomes the last one
        wait_quiet();
        set_size(13'd3, 13'h1FFF);
        feed(7);
        wait_quiet();
        set_size(13'd3, 13'd2);
        feed(FRAME_END);

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && lap_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> laplacian_4_neighbour_stream_core.f
rtl/lap4_pkg.sv
rtl/lap4_ram.sv
rtl/laplacian_4_neighbour_stream_core.sv
tb/tb_laplacian_4_neighbour_stream_core.sv
